[hdl/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

[hdl/llca_pkg.sv]
// shared types and constants of the life-like automaton cell step block
`default_nettype none

package llca_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int SIZE_W  = 7;
    localparam int MASK_W  = 9;
    localparam int COORD_W = 6;
    localparam int COLOR_W = 8;
    localparam int CNT_W   = 4;

    localparam logic [COLOR_W-1:0] ALIVE_COLOR = 8'd255;
    localparam logic [COLOR_W-1:0] DEAD_COLOR  = 8'd0;

    // item kinds carried on tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    // register indexes
    localparam logic [1:0] REG_ROWS    = 2'd0;
    localparam logic [1:0] REG_COLS    = 2'd1;
    localparam logic [1:0] REG_BIRTH   = 2'd2;
    localparam logic [1:0] REG_SURVIVE = 2'd3;

    localparam logic [SIZE_W-1:0] RST_ROWS    = 7'd64;
    localparam logic [SIZE_W-1:0] RST_COLS    = 7'd64;
    localparam logic [MASK_W-1:0] RST_BIRTH   = 9'd8;
    localparam logic [MASK_W-1:0] RST_SURVIVE = 9'd12;

    typedef struct packed {
        logic [SIZE_W-1:0] row_count;
        logic [SIZE_W-1:0] column_count;
        logic [MASK_W-1:0] birth_mask;
        logic [MASK_W-1:0] survive_mask;
    } cfg_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } eng_stat_t;

endpackage

`default_nettype wire

[hdl/llca_ram.sv]
// generic single-port ram with registered read
`default_nettype none

module llca_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[hdl/llca_engine.sv]
// sequencer: grid clearing, cell loads and nine-read neighbour evaluation
`default_nettype none

module llca_engine import llca_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int DEPTH  = MAX_ROWS * MAX_COLS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [23:0]       s_tdata,   // row[5:0], col[11:6], cell_red[19:12], zero
    input  wire logic              s_tuser,   // action
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [15:0]       m_tdata,   // next_color[7:0], out_of_range[8], zero
    output logic                   mem_we,
    output logic      [ADDR_W-1:0] mem_addr,
    output logic                   mem_wdata,
    input  wire logic              mem_rdata,
    output eng_stat_t              stat
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_RESULT
    } state_t;

    localparam logic [CNT_W-1:0] STEP_CENTER = 4'd4;
    localparam logic [CNT_W-1:0] STEP_LAST   = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_END   = ADDR_W'(DEPTH - 1);

    function automatic logic [SIZE_W-1:0] used_size(input logic [SIZE_W-1:0] v,
                                                      input int cap);
        logic [SIZE_W-1:0] res;
        if (v == '0)
            res = SIZE_W'(1);
        else if (int'(v) > cap)
            res = SIZE_W'(cap);
        else
            res = v;
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [SIZE_W-1:0] r,
                                                     input logic [SIZE_W-1:0] c);
        return ADDR_W'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [CNT_W-1:0]  step_reg;
    logic [CNT_W-1:0]  cap_step_reg;
    logic              cap_vld_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              self_reg;
    logic              res_oor_reg;
    logic [SIZE_W-1:0] row_reg, up_reg, down_reg;
    logic [SIZE_W-1:0] col_reg, left_reg, right_reg;
    logic              m_tvalid_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic              m_oor_reg;

    logic [SIZE_W-1:0] rows_used, cols_used;
    logic [SIZE_W-1:0] in_row, in_col, in_row_inc, in_col_inc;
    logic [COLOR_W-1:0] in_red;
    logic              in_oor, accept, out_free, alive;
    logic [SIZE_W-1:0] rd_row, rd_col;

    assign rows_used  = used_size(cfg.row_count, MAX_ROWS);
    assign cols_used  = used_size(cfg.column_count, MAX_COLS);
    assign in_row     = {1'b0, s_tdata[5:0]};
    assign in_col     = {1'b0, s_tdata[11:6]};
    assign in_red     = s_tdata[19:12];
    assign in_row_inc = in_row + SIZE_W'(1);
    assign in_col_inc = in_col + SIZE_W'(1);
    assign in_oor     = (in_row >= rows_used) || (in_col >= cols_used);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign alive    = self_reg ? cfg.survive_mask[cnt_reg] : cfg.birth_mask[cnt_reg];

    // step order: upper row, own row, lower row; left, centre, right in each
    always_comb
    begin
        case (step_reg)
            4'd0: begin rd_row = up_reg;   rd_col = left_reg;  end
            4'd1: begin rd_row = up_reg;   rd_col = col_reg;   end
            4'd2: begin rd_row = up_reg;   rd_col = right_reg; end
            4'd3: begin rd_row = row_reg;  rd_col = left_reg;  end
            4'd5: begin rd_row = row_reg;  rd_col = right_reg; end
            4'd6: begin rd_row = down_reg; rd_col = left_reg;  end
            4'd7: begin rd_row = down_reg; rd_col = col_reg;   end
            4'd8: begin rd_row = down_reg; rd_col = right_reg; end
            default: begin rd_row = row_reg; rd_col = col_reg; end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        mem_addr  = cell_addr(rd_row, rd_col);
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_addr_reg;
            end
            ST_IDLE:
            begin
                mem_we    = accept && (s_tuser == ACT_LOAD) && !in_oor;
                mem_wdata = |in_red;
                mem_addr  = cell_addr(in_row, in_col);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_END)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept && in_oor)
                    state_next = ST_RESULT;
                else if (accept && (s_tuser == ACT_EVAL))
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (step_reg == STEP_LAST)
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cap_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);

            // read data of the previous step lands here
            if (cap_vld_reg)
            begin
                if (cap_step_reg == STEP_CENTER)
                    self_reg <= mem_rdata;
                else
                    cnt_reg <= cnt_reg + CNT_W'(mem_rdata);
            end
            cap_vld_reg  <= (state_reg == ST_READ);
            cap_step_reg <= step_reg;

            if (state_reg == ST_READ)
                step_reg <= step_reg + CNT_W'(1);

            if (accept)
            begin
                res_oor_reg <= in_oor;
                step_reg    <= '0;
                cnt_reg     <= '0;
                self_reg    <= 1'b0;
                row_reg     <= in_row;
                col_reg     <= in_col;
                up_reg      <= (in_row == '0) ? rows_used - SIZE_W'(1)
                                              : in_row - SIZE_W'(1);
                down_reg    <= (in_row_inc == rows_used) ? '0 : in_row_inc;
                left_reg    <= (in_col == '0) ? cols_used - SIZE_W'(1)
                                              : in_col - SIZE_W'(1);
                right_reg   <= (in_col_inc == cols_used) ? '0 : in_col_inc;
            end

            if ((state_reg == ST_RESULT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
                m_oor_reg    <= res_oor_reg;
                m_color_reg  <= (!res_oor_reg && alive) ? ALIVE_COLOR : DEAD_COLOR;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_oor_reg, m_color_reg};

    assign stat.clearing = (state_reg == ST_CLEAR);
    assign stat.busy     = (state_reg != ST_CLEAR) && (state_reg != ST_IDLE);

endmodule

`default_nettype wire

[hdl/life_like_automaton_cell_step.sv]
// top level: configuration registers, grid memory and evaluation sequencer
// One generation of a toroidal cell grid is kept one bit per cell in a
// single-port RAM of MAX_ROWS x MAX_COLS entries, cell (r,c) at r*MAX_COLS+c.
// After reset the block sweeps the RAM clear, one cell a cycle, over all
// MAX_ROWS*MAX_COLS cells (4096 with the defaults); no item is taken during
// the sweep, register writes are. A load transaction (tuser 0) writes its
// cell in the cycle it is accepted and gives no result. An evaluate
// transaction (tuser 1) reads the eight wrapped neighbours and the centre
// through the one RAM port in ST_READ, takes in the last read data in ST_LAST
// and places the result in the output register from ST_RESULT.
// A coordinate outside the sizes in use gives a result of 0 with
// out_of_range set by way of ST_RESULT with no reads, and a load is then dropped.
// A new transaction is accepted while a finished result waits downstream.
`default_nettype none
`include "assert_macros.svh"

module life_like_automaton_cell_step import llca_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // row[5:0], col[11:6], cell_red[19:12], zero
    input  wire logic        s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // next_color[7:0], out_of_range[8], zero
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t              cfg_reg;
    eng_stat_t         stat;
    logic              mem_we, mem_wdata, mem_rdata;
    logic [ADDR_W-1:0] mem_addr;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_count    <= RST_ROWS;
            cfg_reg.column_count <= RST_COLS;
            cfg_reg.birth_mask   <= RST_BIRTH;
            cfg_reg.survive_mask <= RST_SURVIVE;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ROWS:    cfg_reg.row_count    <= pwdata[SIZE_W-1:0];
                REG_COLS:    cfg_reg.column_count <= pwdata[SIZE_W-1:0];
                REG_BIRTH:   cfg_reg.birth_mask   <= pwdata[MASK_W-1:0];
                REG_SURVIVE: cfg_reg.survive_mask <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ROWS:    prdata = 32'(cfg_reg.row_count);
            REG_COLS:    prdata = 32'(cfg_reg.column_count);
            REG_BIRTH:   prdata = 32'(cfg_reg.birth_mask);
            REG_SURVIVE: prdata = 32'(cfg_reg.survive_mask);
            default:     prdata = '0;
        endcase
    end

    llca_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    llca_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .stat      (stat)
    );

    // outside the clearing sweep the grid is only written by an accepted load
    `ASSERT_CLK(a_write_only_on_load, clk, rst_n, (mem_we && !stat.clearing) |-> (s_tvalid && s_tready && (s_tuser == ACT_LOAD)))
    // no transaction is taken while the grid is being cleared
    `ASSERT_NEVER(a_no_accept_in_clear, clk, rst_n, stat.clearing && s_tready)
    // a new result only appears after the sequencer worked on an item
    `ASSERT_CLK(a_result_from_work, clk, rst_n, $rose(m_tvalid) |-> $past(stat.busy))

endmodule

`default_nettype wire

[tb/cell_step_checker.sv]
// watches the cell step block's channels, predicts each next cell state and compares results
`timescale 1ns / 1ps

module cell_step_checker import llca_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [23:0]       s_tdata,   // row[5:0], col[11:6], cell_red[19:12], zero
    input  logic              s_tuser,   // action
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [15:0]       m_tdata,   // next_color[7:0], out_of_range[8], zero
    output int unsigned       mismatch_count,
    output int unsigned       pending_cells
);

    localparam int GRID_ROWS = DEF_MAX_ROWS;
    localparam int GRID_COLS = DEF_MAX_COLS;

    typedef struct packed {
        logic [COLOR_W-1:0] next_color;
        logic               out_of_range;
    } cell_result_t;

    bit                life_grid [GRID_ROWS*GRID_COLS];
    logic [SIZE_W-1:0] row_count_q;
    logic [SIZE_W-1:0] col_count_q;
    logic [MASK_W-1:0] birth_q;
    logic [MASK_W-1:0] survive_q;
    cell_result_t      expected_cells [$];
    cell_result_t      got_cell;
    cell_result_t      want_cell;

    function automatic int unsigned size_in_use(input logic [SIZE_W-1:0] value,
                                                input int unsigned cap);
        if (value == '0)
            return 1;
        if (32'(value) > cap)
            return cap;
        return 32'(value);
    endfunction

    function automatic int unsigned live_at(input int unsigned r, input int unsigned c);
        return 32'(life_grid[r*GRID_COLS + c]);
    endfunction

    task automatic predict_next_state(input logic act, input logic [COORD_W-1:0] r,
                                      input logic [COORD_W-1:0] c,
                                      input logic [COLOR_W-1:0] red);
        int unsigned       rows;
        int unsigned       cols;
        int unsigned       ri;
        int unsigned       ci;
        int unsigned       up;
        int unsigned       down;
        int unsigned       left;
        int unsigned       right;
        int unsigned       count;
        logic [MASK_W-1:0] rule;
        cell_result_t      res;
        rows = size_in_use(row_count_q, GRID_ROWS);
        cols = size_in_use(col_count_q, GRID_COLS);
        ri   = 32'(r);
        ci   = 32'(c);
        if (ri >= rows || ci >= cols)
        begin
            res.next_color   = DEAD_COLOR;
            res.out_of_range = 1'b1;
            expected_cells.push_back(res);
            return;
        end
        if (act == ACT_LOAD)
        begin
            life_grid[ri*GRID_COLS + ci] = (red != '0);
            return;
        end
        // wrapped indices, small grids count the same cell several times
        up    = (ri + rows - 1) % rows;
        down  = (ri + 1) % rows;
        left  = (ci + cols - 1) % cols;
        right = (ci + 1) % cols;
        count = live_at(up, left) + live_at(up, ci) + live_at(up, right)
              + live_at(ri, left) + live_at(ri, right)
              + live_at(down, left) + live_at(down, ci) + live_at(down, right);
        rule = (live_at(ri, ci) != 0) ? survive_q : birth_q;
        res.next_color   = rule[count] ? ALIVE_COLOR : DEAD_COLOR;
        res.out_of_range = 1'b0;
        expected_cells.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (life_grid[i])
                life_grid[i] = 1'b0;
            row_count_q = RST_ROWS;
            col_count_q = RST_COLS;
            birth_q     = RST_BIRTH;
            survive_q   = RST_SURVIVE;
            expected_cells.delete();
            mismatch_count = 0;
            pending_cells <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_ROWS:    row_count_q = pwdata[SIZE_W-1:0];
                    REG_COLS:    col_count_q = pwdata[SIZE_W-1:0];
                    REG_BIRTH:   birth_q     = pwdata[MASK_W-1:0];
                    REG_SURVIVE: survive_q   = pwdata[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got_cell.next_color   = m_tdata[7:0];
                got_cell.out_of_range = m_tdata[8];
                if (expected_cells.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected transaction, next_color %0d out_of_range %0d",
                             $time, got_cell.next_color, got_cell.out_of_range);
                end
                else
                begin
                    want_cell = expected_cells.pop_front();
                    if (got_cell.next_color !== want_cell.next_color)
                    begin
                        mismatch_count++;
                        $display("%0t: next_color expected %0d got %0d",
                                 $time, want_cell.next_color, got_cell.next_color);
                    end
                    if (got_cell.out_of_range !== want_cell.out_of_range)
                    begin
                        mismatch_count++;
                        $display("%0t: out_of_range expected %0d got %0d",
                                 $time, want_cell.out_of_range, got_cell.out_of_range);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_next_state(s_tuser, s_tdata[5:0], s_tdata[11:6], s_tdata[19:12]);
            pending_cells <= expected_cells.size();
        end
    end

endmodule

[tb/life_like_automaton_cell_step_tb.sv]
// top of the cell step testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module life_like_automaton_cell_step_tb import llca_pkg::*; ();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 115;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // row[5:0], col[11:6], cell_red[19:12], zero
    logic        s_tuser  = 1'b0; // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // next_color[7:0], out_of_range[8], zero

    int unsigned       mismatch_count;
    int unsigned       pending_cells;
    int unsigned       cycle_count = 0;
    bit                no_idle     = 1'b0;
    bit                hold_req    = 1'b0;
    logic [SIZE_W-1:0] rows_sel    = RST_ROWS;
    logic [SIZE_W-1:0] cols_sel    = RST_COLS;

    life_like_automaton_cell_step uut (.*);

    cell_step_checker checker_i (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] value);
        if (value == '0)
            return 1;
        if (32'(value) > DEF_MAX_ROWS)
            return DEF_MAX_ROWS;
        return 32'(value);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(9))
            0:       return 7'd0;
            1:       return 7'd127;
            2:       return 7'd64;
            3:       return 7'd1;
            4, 5, 6: return 7'($urandom_range(2, 6));
            7, 8:    return 7'($urandom_range(7, 64));
            default: return 7'($urandom_range(65, 126));
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(9))
            0:       return 9'd0;
            1:       return 9'd511;
            default: return 9'($urandom_range(511));
        endcase
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                             input logic [MASK_W-1:0] birth,
                             input logic [MASK_W-1:0] survive);
        rows_sel = rows;
        cols_sel = cols;
        apb_write(REG_ROWS, 32'(rows));
        apb_write(REG_COLS, 32'(cols));
        apb_write(REG_BIRTH, 32'(birth));
        apb_write(REG_SURVIVE, 32'(survive));
    endtask

    task automatic send_cell(input logic act, input logic [COORD_W-1:0] r,
                             input logic [COORD_W-1:0] c, input logic [COLOR_W-1:0] red);
        if (!no_idle && $urandom_range(99) < 23)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'd0, red, c, r};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // waits for outstanding results and lets a load that gives no result finish before registers change
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_cells != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned        rows_use;
        int unsigned        cols_use;
        int unsigned        load_pct;
        int unsigned        win;
        logic               act;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        logic [COLOR_W-1:0] red;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // full grid after reset, corners and wrap across the top, bottom, left and right edges
        send_cell(ACT_LOAD, 6'd0, 6'd0, 8'd255);
        send_cell(ACT_LOAD, 6'd0, 6'd1, 8'd1);
        send_cell(ACT_LOAD, 6'd1, 6'd0, 8'd128);
        send_cell(ACT_LOAD, 6'd63, 6'd63, 8'd255);
        send_cell(ACT_LOAD, 6'd63, 6'd0, 8'd7);
        send_cell(ACT_LOAD, 6'd0, 6'd63, 8'd0);
        send_cell(ACT_LOAD, 6'd1, 6'd1, 8'd0);
        send_cell(ACT_EVAL, 6'd0, 6'd0, 8'd255);
        send_cell(ACT_EVAL, 6'd63, 6'd63, 8'd0);
        send_cell(ACT_EVAL, 6'd1, 6'd1, 8'd0);
        send_cell(ACT_EVAL, 6'd0, 6'd63, 8'd0);
        wait_drained();

        // zero rows means one row, columns above capacity saturate
        configure(7'd0, 7'd127, RST_BIRTH, RST_SURVIVE);
        send_cell(ACT_LOAD, 6'd0, 6'd5, 8'd255);
        send_cell(ACT_LOAD, 6'd0, 6'd6, 8'd1);
        send_cell(ACT_LOAD, 6'd3, 6'd5, 8'd255);
        send_cell(ACT_EVAL, 6'd0, 6'd5, 8'd0);
        send_cell(ACT_EVAL, 6'd0, 6'd4, 8'd0);
        send_cell(ACT_EVAL, 6'd1, 6'd0, 8'd0);
        wait_drained();

        // two by one torus, all-ones birth and empty survive rules
        configure(7'd2, 7'd1, 9'd511, 9'd0);
        send_cell(ACT_LOAD, 6'd0, 6'd0, 8'd255);
        send_cell(ACT_LOAD, 6'd1, 6'd0, 8'd0);
        send_cell(ACT_EVAL, 6'd0, 6'd0, 8'd0);
        send_cell(ACT_EVAL, 6'd1, 6'd0, 8'd0);
        send_cell(ACT_LOAD, 6'd1, 6'd1, 8'd9);
        send_cell(ACT_EVAL, 6'd0, 6'd1, 8'd0);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
                configure(7'd64, 7'd64, pick_mask(), pick_mask());
            else
                configure(pick_size(), pick_size(), pick_mask(), pick_mask());
            no_idle  = (ph == 3);
            hold_req = (ph == 1);
            load_pct = (ph == 1) ? 20 : 45;
            rows_use = clamp_size(rows_sel);
            cols_use = clamp_size(cols_sel);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                act = ($urandom_range(99) < load_pct) ? ACT_LOAD : ACT_EVAL;
                win = $urandom_range(99);
                if (win < 35)
                begin
                    // dense corner so that neighbor counts get large
                    r = COORD_W'($urandom_range((rows_use > 5) ? 5 : rows_use - 1));
                    c = COORD_W'($urandom_range((cols_use > 5) ? 5 : cols_use - 1));
                end
                else if (win < 85)
                begin
                    r = COORD_W'($urandom_range(rows_use - 1));
                    c = COORD_W'($urandom_range(cols_use - 1));
                end
                else
                begin
                    r = COORD_W'($urandom);
                    c = COORD_W'($urandom);
                end
                red = ($urandom_range(99) < 45) ? 8'd0 : 8'($urandom_range(1, 255));
                send_cell(act, r, c, red);
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
